@@ hdl/frss_pkg.sv @@
// Package for the fractional-rate service scheduler.
// Request/result payload types, command and status codes, controller handshake structs.
// No dependencies.
package frss_pkg;

    // command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_DEL    = 3'd2;
    localparam logic [2:0] CMD_LOCK   = 3'd3;
    localparam logic [2:0] CMD_UNLOCK = 3'd4;

    // status codes
    localparam logic [2:0] ST_FIRED    = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_BAD_ARGS = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOT_INST = 3'd4;

    localparam logic [7:0] LOCK_MAX = 8'd255;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  slot;
        logic [15:0] service_rate;
        logic [7:0]  service_priority;
        logic        start_paused;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] result_slot;
        logic       last;
    } t_res;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch request, evaluate simple commands
        logic advance;   // apply master tick to active slots, latch fire set
        logic scan;      // check one (priority, slot) pair
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic master_tick;  // tick request crosses a master period
        logic any_fired;    // fire set nonempty after advance
        logic scan_done;    // all fired slots reported
    } t_sts;

endpackage

@@ hdl/fractional_rate_service_scheduler.sv @@
// Top level of the fractional-rate service scheduler.
// Depends on frss_pkg, frss_ctrl, frss_dp.
//
// Requests are taken when start is high and busy low; results appear
// one per cycle-with-strobe on o_res_valid/o_res and cannot be held off.
// Add, delete, lock, unlock and ticks without a master tick give their
// single result in the cycle right after the request; busy is high while
// that result is shown, so no new request is taken in the same cycle.
// A tick that makes a master tick passes through evaluation, advances
// every active slot in the next state, then sweeps (priority, slot) pairs
// one per cycle until the last fired slot is reported; the sweep ends
// sooner when fired slots have low priority values. A master tick with
// no fire reports after the advance state. master_rate is written
// through i_cfg_we/i_cfg_data.
module fractional_rate_service_scheduler #(
    parameter int NUM_SLOTS = 16,
    parameter int SOURCE_HZ = 44100
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    input  logic            start,
    output logic            busy,
    input  frss_pkg::t_req  i_req,
    output logic            o_res_valid,
    output frss_pkg::t_res  o_res
);

    frss_pkg::t_ctl ctl;
    frss_pkg::t_sts sts;

    frss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    frss_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .SOURCE_HZ (SOURCE_HZ)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // a request is never taken while busy
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |-> !busy) else $error("load while busy");

    // a result of a plain request follows in the cycle after the load
    a_simple_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load && i_req.cmd != frss_pkg::CMD_TICK |=> o_res_valid && o_res.last)
        else $error("missing result");

    // a result that is not the last comes only while busy
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |-> busy) else $error("stray result");

endmodule

@@ hdl/frss_ctrl.sv @@
// Controller state machine for the fractional-rate service scheduler.
// Depends on frss_pkg.
module frss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  frss_pkg::t_sts  i_sts,
    output frss_pkg::t_ctl  o_ctl,
    output logic            o_busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_ADV   = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_EVAL;
            S_EVAL: n_state = i_sts.master_tick ? S_ADV : S_IDLE;
            S_ADV:  n_state = i_sts.any_fired ? S_SCAN : S_IDLE;
            S_SCAN: if (i_sts.scan_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl.load    = (r_state == S_IDLE) && i_start;
    assign o_ctl.advance = (r_state == S_ADV);
    assign o_ctl.scan    = (r_state == S_SCAN);
    assign o_busy        = (r_state != S_IDLE);

endmodule

@@ hdl/frss_dp.sv @@
// Datapath for the fractional-rate service scheduler: slot table, phases, lock, scan.
// Depends on frss_pkg.
module frss_dp #(
    parameter int NUM_SLOTS = 16,
    parameter int SOURCE_HZ = 44100
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    input  frss_pkg::t_req  i_req,
    input  frss_pkg::t_ctl  i_ctl,
    output frss_pkg::t_sts  o_sts,
    output logic            o_res_valid,
    output frss_pkg::t_res  o_res
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [16:0] SRC = 17'(SOURCE_HZ);

    logic [NUM_SLOTS-1:0] r_used, r_paused, r_fired;
    logic [15:0] r_rate  [NUM_SLOTS];
    logic [15:0] r_phase [NUM_SLOTS];
    logic [7:0]  r_prio  [NUM_SLOTS];
    logic [15:0] r_mrate, r_mphase;
    logic [7:0]  r_lock;
    logic        r_tick;     // pending master tick
    logic [7:0]  r_pval;     // priority being scanned
    logic [SW-1:0] r_sidx;   // slot being scanned
    logic        r_res_valid;
    frss_pkg::t_res r_res;

    // lowest free slot
    logic [SW-1:0] free_idx;
    logic          free_ok;
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = SW'(i);
                free_ok  = 1'b1;
            end
        end
    end

    logic [16:0] mph_sum;
    logic        can_tick;
    assign mph_sum  = {1'b0, r_mphase} + {1'b0, r_mrate};
    assign can_tick = (r_mrate != 16'd0) && (r_lock == 8'd0);

    // scan: one slot per cycle, priority outer, slot inner
    logic hit, last_slot, more;
    logic [NUM_SLOTS-1:0] fired_after;
    always_comb begin
        hit = r_fired[r_sidx] && (r_prio[r_sidx] == r_pval);
        fired_after = r_fired;
        if (hit) fired_after[r_sidx] = 1'b0;
        last_slot = (r_sidx == SW'(NUM_SLOTS - 1));
        more = |fired_after;
    end

    // per-slot phase update on a master tick
    logic [16:0] ph_sum [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] fire_now;
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            ph_sum[i]   = {1'b0, r_phase[i]} + {1'b0, r_rate[i]};
            fire_now[i] = r_used[i] && !r_paused[i] && (ph_sum[i] >= {1'b0, r_mrate});
        end
    end

    // fire set of the advance being applied decides whether a sweep follows
    assign o_sts.master_tick = r_tick;
    assign o_sts.any_fired   = |fire_now;
    assign o_sts.scan_done   = !more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0; r_paused <= '0; r_fired <= '0;
            r_mrate <= '0; r_mphase <= '0; r_lock <= '0;
            r_tick <= 1'b0; r_res_valid <= 1'b0;
            r_pval <= '0; r_sidx <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_rate[i] <= '0; r_phase[i] <= '0; r_prio[i] <= '0;
            end
        end else begin
            r_res_valid <= 1'b0;
            r_tick      <= 1'b0;
            // an accepted register write (at most SOURCE_HZ) clears the table
            if (i_cfg_we && ({1'b0, i_cfg_data} <= SRC)) begin
                r_mrate <= i_cfg_data;
                r_used <= '0; r_paused <= '0; r_mphase <= '0; r_lock <= '0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    r_rate[i] <= '0; r_phase[i] <= '0; r_prio[i] <= '0;
                end
            end
            // evaluate a new request
            if (i_ctl.load) begin
                r_res_valid       <= 1'b1;
                r_res.status      <= frss_pkg::ST_DONE;
                r_res.result_slot <= '0;
                r_res.last        <= 1'b1;
                unique case (i_req.cmd)
                    frss_pkg::CMD_TICK: begin
                        if (can_tick) begin
                            if (mph_sum >= SRC) begin
                                r_mphase    <= 16'(mph_sum - SRC);
                                r_tick      <= 1'b1;
                                r_res_valid <= 1'b0;
                            end else begin
                                r_mphase <= mph_sum[15:0];
                            end
                        end
                    end
                    frss_pkg::CMD_ADD: begin
                        if (r_mrate == 16'd0) begin
                            r_res.status <= frss_pkg::ST_NOT_INST;
                        end else if (i_req.service_rate == 16'd0 ||
                                     i_req.service_rate > r_mrate) begin
                            r_res.status <= frss_pkg::ST_BAD_ARGS;
                        end else if (!free_ok) begin
                            r_res.status <= frss_pkg::ST_FULL;
                        end else begin
                            r_used[free_idx]   <= 1'b1;
                            r_paused[free_idx] <= i_req.start_paused;
                            r_rate[free_idx]   <= i_req.service_rate;
                            r_phase[free_idx]  <= '0;
                            r_prio[free_idx]   <= i_req.service_priority;
                            r_res.result_slot  <= 4'(free_idx);
                        end
                    end
                    frss_pkg::CMD_DEL: begin
                        if (32'(i_req.slot) < NUM_SLOTS) begin
                            r_used[SW'(i_req.slot)]   <= 1'b0;
                            r_paused[SW'(i_req.slot)] <= 1'b0;
                            r_rate[SW'(i_req.slot)]   <= '0;
                            r_phase[SW'(i_req.slot)]  <= '0;
                            r_prio[SW'(i_req.slot)]   <= '0;
                        end
                    end
                    frss_pkg::CMD_LOCK: begin
                        if (r_lock != frss_pkg::LOCK_MAX) r_lock <= r_lock + 8'd1;
                    end
                    frss_pkg::CMD_UNLOCK: begin
                        if (r_lock != 8'd0) r_lock <= r_lock - 8'd1;
                    end
                    default: r_res.status <= frss_pkg::ST_BAD_ARGS;
                endcase
            end
            // master tick: advance every active slot
            if (i_ctl.advance) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (r_used[i] && !r_paused[i]) begin
                        r_phase[i] <= fire_now[i] ? 16'(ph_sum[i] - {1'b0, r_mrate})
                                                  : ph_sum[i][15:0];
                    end
                end
                r_fired <= fire_now;
                r_pval  <= '0;
                r_sidx  <= '0;
                if (!(|fire_now)) begin
                    r_res_valid       <= 1'b1;
                    r_res.status      <= frss_pkg::ST_DONE;
                    r_res.result_slot <= '0;
                    r_res.last        <= 1'b1;
                end
            end
            // report fired slots in (priority, slot) order
            if (i_ctl.scan) begin
                r_fired <= fired_after;
                if (last_slot) begin
                    r_sidx <= '0;
                    r_pval <= r_pval + 8'd1;
                end else begin
                    r_sidx <= r_sidx + SW'(1);
                end
                if (hit) begin
                    r_res_valid       <= 1'b1;
                    r_res.status      <= frss_pkg::ST_FIRED;
                    r_res.result_slot <= 4'(r_sidx);
                    r_res.last        <= !more;
                end
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ test/fractional_rate_service_scheduler_test.sv @@
// Self-checking testbench for fractional_rate_service_scheduler.
// Depends on frss_pkg and the scheduler RTL; it predicts every result in place
// and checks the result stream under random request gaps.
module fractional_rate_service_scheduler_test;

    localparam int NSLOT     = 16;
    localparam int SRC_HZ    = 44100;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 16;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic [15:0]    i_cfg_data;
    logic           start;
    logic           busy;
    frss_pkg::t_req i_req;
    logic           o_res_valid;
    frss_pkg::t_res o_res;

    fractional_rate_service_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // scheduler shadow state
    logic        sh_used  [NSLOT];
    logic        sh_pause [NSLOT];
    int unsigned sh_rate  [NSLOT];
    int unsigned sh_phase [NSLOT];
    logic [7:0]  sh_prio  [NSLOT];
    int unsigned sh_mphase;
    int unsigned sh_lock;
    int unsigned sh_mrate;

    frss_pkg::t_req pending_requests[$];
    frss_pkg::t_res expected_results[$];
    int   sender_idle_pct;
    bit   hold_requests;
    int   mismatches;
    int   quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic frss_pkg::t_res mk_res(logic [2:0] st, int unsigned sl, logic lst);
        frss_pkg::t_res r;
        r.status      = st;
        r.result_slot = sl[3:0];
        r.last        = lst;
        return r;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < NSLOT; i++) begin
            sh_used[i]  = 1'b0;
            sh_pause[i] = 1'b0;
            sh_rate[i]  = 0;
            sh_phase[i] = 0;
            sh_prio[i]  = '0;
        end
        sh_mphase = 0;
        sh_lock   = 0;
    endfunction

    function automatic void apply_master_rate(logic [15:0] v);
        // out-of-range writes leave everything untouched
        if (v <= SRC_HZ) begin
            clear_shadow();
            sh_mrate = v;
        end
    endfunction

    // master tick: advance every live slot, report fires by (priority, slot)
    function automatic void advance_master_tick();
        logic           fired [NSLOT];
        int unsigned    p;
        int             n;
        frss_pkg::t_res r;
        n = 0;
        if (sh_mrate == 0 || sh_lock != 0) begin
            expected_results.push_back(mk_res(frss_pkg::ST_DONE, 0, 1'b1));
            return;
        end
        p = sh_mphase + sh_mrate;
        if (p < SRC_HZ) begin
            sh_mphase = p;
            expected_results.push_back(mk_res(frss_pkg::ST_DONE, 0, 1'b1));
            return;
        end
        sh_mphase = p - SRC_HZ;
        for (int i = 0; i < NSLOT; i++) begin
            fired[i] = 1'b0;
            if (sh_used[i] && !sh_pause[i]) begin
                p = sh_phase[i] + sh_rate[i];
                if (p >= sh_mrate) begin
                    p = p - sh_mrate;
                    fired[i] = 1'b1;
                end
                sh_phase[i] = p;
            end
        end
        for (int pr = 0; pr < 256; pr++)
            for (int i = 0; i < NSLOT; i++)
                if (fired[i] && sh_prio[i] == pr[7:0]) begin
                    expected_results.push_back(mk_res(frss_pkg::ST_FIRED, i, 1'b0));
                    n++;
                end
        if (n == 0) begin
            expected_results.push_back(mk_res(frss_pkg::ST_DONE, 0, 1'b1));
        end else begin
            r = expected_results.pop_back();
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endfunction

    function automatic void schedule_request(frss_pkg::t_req q);
        int fr;
        fr = -1;
        case (q.cmd)
            frss_pkg::CMD_TICK: advance_master_tick();
            frss_pkg::CMD_ADD: begin
                if (sh_mrate == 0) begin
                    expected_results.push_back(mk_res(frss_pkg::ST_NOT_INST, 0, 1'b1));
                end else if (q.service_rate == 0 || q.service_rate > sh_mrate) begin
                    expected_results.push_back(mk_res(frss_pkg::ST_BAD_ARGS, 0, 1'b1));
                end else begin
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!sh_used[i]) fr = i;
                    if (fr < 0) begin
                        expected_results.push_back(mk_res(frss_pkg::ST_FULL, 0, 1'b1));
                    end else begin
                        sh_used[fr]  = 1'b1;
                        sh_pause[fr] = q.start_paused;
                        sh_rate[fr]  = q.service_rate;
                        sh_phase[fr] = 0;
                        sh_prio[fr]  = q.service_priority;
                        expected_results.push_back(mk_res(frss_pkg::ST_DONE, fr, 1'b1));
                    end
                end
            end
            frss_pkg::CMD_DEL: begin
                sh_used[q.slot]  = 1'b0;
                sh_pause[q.slot] = 1'b0;
                sh_rate[q.slot]  = 0;
                sh_phase[q.slot] = 0;
                sh_prio[q.slot]  = '0;
                expected_results.push_back(mk_res(frss_pkg::ST_DONE, 0, 1'b1));
            end
            frss_pkg::CMD_LOCK: begin
                if (sh_lock < frss_pkg::LOCK_MAX) sh_lock++;
                expected_results.push_back(mk_res(frss_pkg::ST_DONE, 0, 1'b1));
            end
            frss_pkg::CMD_UNLOCK: begin
                if (sh_lock != 0) sh_lock--;
                expected_results.push_back(mk_res(frss_pkg::ST_DONE, 0, 1'b1));
            end
            default: expected_results.push_back(mk_res(frss_pkg::ST_BAD_ARGS, 0, 1'b1));
        endcase
    endfunction

    // request driver; while held, a new request waits for all results
    always @(posedge i_clk) begin
        logic           take;
        frss_pkg::t_req nxt;
        take = 1'b0;
        nxt  = i_req;
        if (i_rst_n) begin
            if (start && !busy) begin
                schedule_request(i_req);
                void'(pending_requests.pop_front());
            end
            if (start && busy) begin
                take = 1'b1;
            end else if (pending_requests.size() != 0
                         && !(hold_requests && expected_results.size() != 0)
                         && $urandom_range(99) >= sender_idle_pct) begin
                take = 1'b1;
                nxt  = pending_requests[0];
            end
        end
        start <= take;
        i_req <= nxt;
    end

    // result monitor
    always @(posedge i_clk) begin
        frss_pkg::t_res want;
        if (i_rst_n && o_res_valid) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status=%0d slot=%0d last=%0b",
                             o_res.status, o_res.result_slot, o_res.last);
            end else begin
                want = expected_results.pop_front();
                if (o_res.status !== want.status || o_res.result_slot !== want.result_slot
                    || o_res.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.status, want.result_slot, want.last,
                                 o_res.status, o_res.result_slot, o_res.last);
                end
            end
        end
    end

    // watchdog: cycles with neither a request taken nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("fractional_rate_service_scheduler_test: FAIL");
                $finish;
            end
        end
    end

    function automatic frss_pkg::t_req mk_req(logic [2:0] c, int sl, int unsigned rt,
                                              int pr, bit pz);
        frss_pkg::t_req q;
        q.cmd              = c;
        q.slot             = sl[3:0];
        q.service_rate     = rt[15:0];
        q.service_priority = pr[7:0];
        q.start_paused     = pz;
        return q;
    endfunction

    // random request mix: mostly ticks and adds with sane arguments
    function automatic frss_pkg::t_req rand_req();
        frss_pkg::t_req q;
        int unsigned    k;
        q = frss_pkg::t_req'($urandom);
        k = $urandom_range(99);
        if (k < 50)      q.cmd = frss_pkg::CMD_TICK;
        else if (k < 70) q.cmd = frss_pkg::CMD_ADD;
        else if (k < 82) q.cmd = frss_pkg::CMD_DEL;
        else if (k < 88) q.cmd = frss_pkg::CMD_LOCK;
        else if (k < 96) q.cmd = frss_pkg::CMD_UNLOCK;
        else             q.cmd = 3'($urandom_range(7, 5));
        if ($urandom_range(9) < 7 && sh_mrate != 0)
            q.service_rate = 16'($urandom_range(sh_mrate, 1));
        if ($urandom_range(99) >= 3)
            q.service_priority = 8'($urandom_range(15));
        if ($urandom_range(3) != 0)
            q.start_paused = 1'b0;
        return q;
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || start || expected_results.size() != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_master_rate(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        apply_master_rate(v);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) pending_requests.push_back(rand_req());
        wait_idle();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        start           = 1'b0;
        i_req           = '0;
        sender_idle_pct = 35;
        hold_requests   = 1'b0;
        mismatches      = 0;
        quiet_cycles    = 0;
        clear_shadow();
        sh_mrate = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // not installed: ticks, adds, a lock and an extra unlock, unknown commands, a delete
        pending_requests.push_back(mk_req(frss_pkg::CMD_TICK, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_ADD, 0, 100, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_LOCK, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_UNLOCK, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_UNLOCK, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(3'd5, 15, 16'hFFFF, 255, 1));
        pending_requests.push_back(mk_req(3'd7, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_DEL, 15, 0, 0, 0));
        wait_idle();

        // full rate: argument checks, fill the table, overflow, fire sweep
        write_master_rate(16'd44100);
        pending_requests.push_back(mk_req(frss_pkg::CMD_ADD, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_ADD, 0, 44101, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_ADD, 0, 44100, 255, 1));
        for (int i = 1; i < NSLOT; i++)
            pending_requests.push_back(mk_req(frss_pkg::CMD_ADD, 0, 2756 * i, 15 - i, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_ADD, 0, 1, 0, 0));
        for (int i = 0; i < 4; i++)
            pending_requests.push_back(mk_req(frss_pkg::CMD_TICK, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_DEL, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_ADD, 0, 44100, 255, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_TICK, 0, 0, 0, 0));
        wait_idle();

        // out-of-range write is ignored: table keeps firing as before
        write_master_rate(16'hFFFF);
        for (int i = 0; i < 4; i++)
            pending_requests.push_back(mk_req(frss_pkg::CMD_TICK, 0, 0, 0, 0));
        // lock depth saturation, then locked ticks around one unlock
        for (int i = 0; i < 257; i++)
            pending_requests.push_back(mk_req(frss_pkg::CMD_LOCK, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_TICK, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_UNLOCK, 0, 0, 0, 0));
        pending_requests.push_back(mk_req(frss_pkg::CMD_TICK, 0, 0, 0, 0));

        // each request waits until every earlier result has come
        hold_requests = 1'b1;
        wait_idle();
        hold_requests = 1'b0;

        write_master_rate(16'd1000);
        random_phase(16);
        write_master_rate(16'd0);
        random_phase(14);

        sender_idle_pct = 69;
        write_master_rate(16'd1);
        random_phase(12);
        write_master_rate(16'd30000);
        random_phase(14);

        sender_idle_pct = 0;
        write_master_rate(16'd44100);
        random_phase(26);

        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("fractional_rate_service_scheduler_test: PASS");
        end else begin
            $display("fractional_rate_service_scheduler_test: FAIL");
        end
        $finish;
    end

endmodule

@@ fractional_rate_service_scheduler.f @@
hdl/frss_pkg.sv
hdl/frss_ctrl.sv
hdl/frss_dp.sv
hdl/fractional_rate_service_scheduler.sv
test/fractional_rate_service_scheduler_test.sv
